FILE: hw/rtl/adfp_pkg.sv
package adfp_pkg;

  // Characters of the sensor frame "e:0 ... d:<digits>m".
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned DistW = 16;

  typedef enum logic [2:0] {
    ST_WAIT_E   = 3'd0,
    ST_COLON_E  = 3'd1,
    ST_ZERO     = 3'd2,
    ST_WAIT_D   = 3'd3,
    ST_COLON_D  = 3'd4,
    ST_DIGITS   = 3'd5
  } parse_state_t;

  // Outcome of one byte: the new parser state and whether a frame completed.
  typedef struct packed {
    parse_state_t state;
    logic [DistW-1:0] acc;
    logic emit;
  } step_result_t;

endpackage

FILE: hw/rtl/ascii_distance_frame_parser.sv
// A byte is registered on acceptance and, if it ends a frame, its distance is loaded
// into the result register as the byte moves through the parser step, which a
// stalled result can hold back.
// Throughput: one byte per cycle while no result is stalled, set by the combinational
// parser step between the input and result registers; a stalled result holds both.
// Reset (rst, synchronous, active high) returns the parser to waiting for 'e',
// clears the accumulator and empties the input and result registers.
module ascii_distance_frame_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rx_valid,
  output logic                        rx_stall,
  input  logic [7:0]                  rx_byte,
  output logic                        distance_valid,
  input  logic                        distance_stall,
  output logic [adfp_pkg::DistW-1:0]  distance
);
  import adfp_pkg::*;

  // Input register: holds one received byte until the parser step takes it.
  logic             byte_valid;
  logic [7:0]       byte_reg;

  // Parser state, updated only when a byte moves through the step.
  parse_state_t     state;
  logic [DistW-1:0] acc;

  // Result register in front of the output channel.
  logic             out_valid;
  logic [DistW-1:0] out_distance;

  step_result_t     step;
  logic             advance;
  logic             rx_take;

  adfp_step u_step (
    .state   (state),
    .acc     (acc),
    .rx_byte (byte_reg),
    .result  (step)
  );

  // The held byte is consumed whenever the result register is empty or is
  // being drained in this cycle. While a result waits under a stall, every
  // byte is held, since the step could complete another frame.
  assign advance  = byte_valid && (!out_valid || !distance_stall);
  assign rx_stall = byte_valid && !advance;
  assign rx_take  = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx_take) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      byte_reg <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT_E;
      acc   <= '0;
    end else if (advance) begin
      state <= step.state;
      acc   <= step.acc;
    end
  end

  // A completed frame loads the result register; otherwise a transaction on
  // the output channel empties it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step.emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !distance_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.emit) begin
      out_distance <= acc;
    end
  end

  assign distance_valid = out_valid;
  assign distance       = out_distance;

endmodule

FILE: hw/rtl/adfp_step.sv
module adfp_step (
  input  adfp_pkg::parse_state_t              state,
  input  logic [adfp_pkg::DistW-1:0]          acc,
  input  logic [7:0]                          rx_byte,
  output adfp_pkg::step_result_t              result
);
  import adfp_pkg::*;

  logic                 is_digit;
  logic [DistW-1:0]     acc_times_ten;
  logic [DistW-1:0]     digit_value;
  parse_state_t         state_next;

  assign is_digit      = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  // acc*10 as (acc << 3) + (acc << 1), wrapping at the field width.
  assign acc_times_ten = {acc[DistW-4:0], 3'b000} + {acc[DistW-2:0], 1'b0};
  assign digit_value   = {{(DistW-4){1'b0}}, rx_byte[3:0] - CH_ZERO[3:0]};

  always_comb begin
    unique case (state)
      ST_COLON_E: state_next = (rx_byte == CH_COLON) ? ST_ZERO : ST_WAIT_E;
      ST_ZERO:    state_next = (rx_byte == CH_ZERO) ? ST_WAIT_D : ST_WAIT_E;
      ST_WAIT_D:  state_next = (rx_byte == CH_D) ? ST_COLON_D : ST_WAIT_D;
      ST_COLON_D: state_next = (rx_byte == CH_COLON) ? ST_DIGITS : ST_WAIT_D;
      ST_DIGITS: begin
        if ((rx_byte == CH_SPACE) || is_digit) begin
          state_next = ST_DIGITS;
        end else begin
          state_next = ST_WAIT_E;
        end
      end
      default:    state_next = (rx_byte == CH_E) ? ST_COLON_E : ST_WAIT_E;
    endcase
  end

  always_comb begin
    result.state = state_next;
    result.acc   = acc;
    result.emit  = 1'b0;
    unique case (state)
      ST_COLON_D: begin
        if (rx_byte == CH_COLON) begin
          result.acc = '0;
        end
      end
      ST_DIGITS: begin
        if (is_digit) begin
          result.acc = acc_times_ten + digit_value;
        end else if (rx_byte == CH_M) begin
          result.emit = 1'b1;
        end
      end
      default: begin
        result.acc = acc;
      end
    endcase
  end

endmodule

FILE: test/distance_frame_checker.sv
module distance_frame_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rx_valid,
  input  logic                       rx_stall,
  input  logic [7:0]                 rx_byte,
  input  logic                       distance_valid,
  input  logic                       distance_stall,
  input  logic [adfp_pkg::DistW-1:0] distance,
  output int                         fail_count,
  output int                         frames_pending,
  output int                         frames_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import adfp_pkg::*;

  parse_state_t     parser_state;
  logic [DistW-1:0] distance_acc;
  logic [DistW-1:0] oldest_distance;
  logic [DistW-1:0] expected_distances[$];

  // Advances the parser by one byte and queues the distance when a frame completes.
  task automatic parse_sensor_byte(input logic [7:0] b);
    case (parser_state)
      ST_COLON_E: parser_state = (b == CH_COLON) ? ST_ZERO : ST_WAIT_E;
      ST_ZERO:    parser_state = (b == CH_ZERO) ? ST_WAIT_D : ST_WAIT_E;
      ST_WAIT_D: begin
        if (b == CH_D) parser_state = ST_COLON_D;
      end
      ST_COLON_D: begin
        if (b == CH_COLON) begin
          distance_acc = '0;
          parser_state = ST_DIGITS;
        end else begin
          parser_state = ST_WAIT_D;
        end
      end
      ST_DIGITS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          distance_acc = DistW'(distance_acc * 10 + (b - CH_ZERO));
        end else if (b != CH_SPACE) begin
          if (b == CH_M) expected_distances.push_back(distance_acc);
          parser_state = ST_WAIT_E;
        end
      end
      // The unused state codes behave like waiting for the letter e.
      default: parser_state = (b == CH_E) ? ST_COLON_E : ST_WAIT_E;
    endcase
  endtask

  // A result accepted at an edge always belongs to an earlier byte, so it is
  // checked before the byte accepted at the same edge is parsed.
  always @(posedge clk) begin
    if (rst) begin
      parser_state = ST_WAIT_E;
      distance_acc = '0;
      expected_distances = {};
      fail_count = 0;
      frames_checked = 0;
    end else begin
      if (distance_valid && !distance_stall) begin
        if (expected_distances.size() == 0) begin
          $error("distance: expected no transaction, actual %0d", distance);
          fail_count++;
        end else begin
          oldest_distance = expected_distances.pop_front();
          frames_checked++;
          if (distance !== oldest_distance) begin
            $error("distance: expected %0d, actual %0d", oldest_distance, distance);
            fail_count++;
          end
        end
      end
      if (rx_valid && !rx_stall) parse_sensor_byte(rx_byte);
    end
    frames_pending = expected_distances.size();
  end

endmodule

FILE: test/ascii_distance_frame_parser_tb.sv
module ascii_distance_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import adfp_pkg::*;

  // Number of random bytes sent after the directed part, spread over four
  // phases that differ in how often the sender idles and the receiver stalls.
  localparam int RandomBytes = 920;
  localparam int DrainCycles = 8;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             rx_valid = 1'b0;
  logic             rx_stall;
  logic [7:0]       rx_byte = 8'h00;
  logic             distance_valid;
  logic             distance_stall = 1'b0;
  logic [DistW-1:0] distance;

  int fail_count;
  int frames_pending;
  int frames_checked;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int bytes_sent = 0;
  int idle_by_phase[4] = '{0, 61, 0, 24};
  int stall_by_phase[4] = '{0, 0, 61, 24};

  // Bytes of the frame that is about to be sent.
  logic [7:0] frame_bytes[$];

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ascii_distance_frame_parser dut (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .distance_valid (distance_valid),
    .distance_stall (distance_stall),
    .distance       (distance)
  );

  distance_frame_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .distance_valid (distance_valid),
    .distance_stall (distance_stall),
    .distance       (distance),
    .fail_count     (fail_count),
    .frames_pending (frames_pending),
    .frames_checked (frames_checked)
  );

  // The receiver decides afresh at every falling edge whether to stall, so
  // stalls land on every phase of the parser's work.
  always @(negedge clk) begin
    distance_stall <= !rst && ($urandom_range(99) < receiver_stall_pct);
  end

  // Offers one byte, with random idle cycles first, and returns at the falling
  // edge after the transaction has been accepted. Valid stays high when the
  // next byte follows without a gap.
  task automatic send_sensor_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_sensor_byte(s[i]);
  endtask

  task automatic send_frame_bytes();
    foreach (frame_bytes[i]) send_sensor_byte(frame_bytes[i]);
    frame_bytes = {};
  endtask

  // Builds one random frame. Most are well formed with random noise before
  // the header, random filler before "d:", and a random digit run with
  // spaces mixed in. Some lose their closing letter, some get one byte
  // overwritten, and a few are pure noise. Long digit runs overflow the
  // 16-bit distance and exercise the wrap-around.
  task automatic build_random_frame();
    int n_digits;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(8, 1)) frame_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(CH_E);
      frame_bytes.push_back(CH_COLON);
      frame_bytes.push_back(CH_ZERO);
      repeat ($urandom_range(3)) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(CH_D);
      frame_bytes.push_back(CH_COLON);
      n_digits = ($urandom_range(9) == 0) ? $urandom_range(9, 6) : $urandom_range(5);
      repeat (n_digits) begin
        if ($urandom_range(4) == 0) frame_bytes.push_back(CH_SPACE);
        frame_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
      end
      frame_bytes.push_back(($urandom_range(7) == 0) ? 8'($urandom) : CH_M);
      if ($urandom_range(6) == 0) begin
        frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom);
      end
    end
  endtask

  initial begin
    int quota;
    // Reset is held and then released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: the lowest and highest byte values while waiting for the
    // header, a frame with no digits at all (distance zero), a frame whose
    // filler holds a lone 'd' and whose spaced digits overflow 16 bits, and
    // headers broken at the colon and at the zero.
    send_sensor_byte(8'h00);
    send_sensor_byte(8'hFF);
    send_text("e:0d:m");
    send_text("e:0dxd:9 9999m");
    send_text("exe:1");

    // Random part, one phase per idle and stall mix; the first phase runs
    // without any gaps at all.
    quota = bytes_sent;
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_by_phase[phase];
      receiver_stall_pct = stall_by_phase[phase];
      quota += RandomBytes / 4;
      while (bytes_sent < quota) begin
        build_random_frame();
        send_frame_bytes();
      end
    end
    rx_valid <= 1'b0;
    receiver_stall_pct = 0;

    // Wait until every predicted distance has come out, then keep the clock running for
    // DrainCycles more so that any stray result is still caught.
    while (frames_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Sent %0d sensor bytes under four idle and stall mixes; %0d distance frames compared.",
             bytes_sent, frames_checked);
    if (fail_count == 0 && frames_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: the slowest correct run takes well under a tenth of this.
  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule
